### design/pulsatile_pump_phase_sequencer_assert.svh
// Assertion shorthands shared by the sequencer RTL.
`ifndef PULSATILE_PUMP_PHASE_SEQUENCER_ASSERT_SVH
`define PULSATILE_PUMP_PHASE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPPS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPPS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ppps_pkg.sv
package ppps_pkg;

    // defaults for the top-level parameters
    localparam int START_RATE_BPM_DEF = 60;
    localparam int STROKE_STEPS_DEF   = 1600;
    localparam int REV_STEPS_DEF      = 3200;

    // field widths
    localparam int POS_W    = 32;
    localparam int REQ_W    = 3;
    localparam int PCT_W    = 7;
    localparam int RATE_W   = 7;
    localparam int STROKE_W = 16;
    localparam int CNT_W    = 16;
    localparam int CYC_W    = 11;   // 60000/30 = 2000
    localparam int PROD_W   = 18;   // 2000 * 127

    // serial divider
    localparam int DIV_DW = 20;     // 65535*11+5 fits
    localparam int DIV_VW = 7;

    // digit-serial adder
    localparam int DIG_W     = 4;
    localparam int ADD_STEPS = POS_W / DIG_W;
    localparam int ADD_CW    = $clog2(ADD_STEPS);
    localparam int MUL_CW    = $clog2(PCT_W);

    // constants
    localparam int PCT_RESET   = 35;
    localparam int MS_PER_MIN  = 60000;
    localparam int PCT_SCALE   = 100;
    localparam int RATE_MIN    = 30;
    localparam int RATE_MAX    = 120;
    localparam int RATE_STEP   = 5;
    localparam int STROKE_MIN  = 10;
    localparam int STROKE_DIV  = 10;
    localparam int ROUND_HALF  = 5;

    // result beat packing
    localparam int OUT_FIELDS_W = 77;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_START     = 3'd1,
        REQ_STOP      = 3'd2,
        REQ_ESTOP     = 3'd3,
        REQ_RATE_UP   = 3'd4,
        REQ_RATE_DN   = 3'd5,
        REQ_STROKE_UP = 3'd6,
        REQ_STROKE_DN = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYS  = 2'd1,
        PH_DIA  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CYC,
        ST_MUL,
        ST_SYS_GO,
        ST_SYS,
        ST_EVAL,
        ST_STROKE,
        ST_ADD,
        ST_FIN
    } seq_state_t;

endpackage

### design/ppps_div.sv
module ppps_div #(
    parameter int DW = ppps_pkg::DIV_DW,
    parameter int VW = ppps_pkg::DIV_VW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   part;
    logic [VW+1:0] diff;

    // restoring division, one quotient bit per cycle
    assign part = {rem_reg, quo_reg[DW-1]};
    assign diff = {1'b0, part} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[VW+1]) begin
                rem_reg <= diff[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= part[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/pulsatile_pump_phase_sequencer.sv
// Channel   | Dir | Handshake            | Contents
// ----------+-----+----------------------+---------------------------------------
// s_axis    | in  | tvalid/tready        | tuser: req_type; tdata: current_position
// m_axis    | out | tvalid/tready        | tuser: move_valid, cycle_done; tdata: rest
// cfg       | in  | cfg_we (no stall)    | systole_percent
//
// A running tick makes two 20-bit passes of the serial divider (cycle length,
// then systole share) with a shift-add multiply between them, a state each to
// launch the second divide and to compare, and, when it issues a move, the
// 4-bit adder for the target, all between the accept and result states.
// Stroke commands make one divide, start one add, and other beats go straight
// to the result state.
// Synchronous active-low reset; no clearing pass. The result register lets a
// new beat in while a result is still waiting; a stalled m_axis holds the
// sequencer in its final state until the result register frees up.

`include "pulsatile_pump_phase_sequencer_assert.svh"

module pulsatile_pump_phase_sequencer #(
    parameter int START_RATE_BPM = ppps_pkg::START_RATE_BPM_DEF,
    parameter int STROKE_STEPS   = ppps_pkg::STROKE_STEPS_DEF,
    parameter int REV_STEPS      = ppps_pkg::REV_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] current_position
    input  logic [ppps_pkg::POS_W-1:0]      s_axis_tdata,
    // [2:0] req_type
    input  logic [ppps_pkg::REQ_W-1:0]      s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] phase, [33:2] target_position, [34] speed_profile,
    // [35] stop_motion, [36] zero_position, [37] drive_enable,
    // [53:38] cycle_length_ms, [60:54] heart_rate, [76:61] stroke_steps
    output logic [ppps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] move_valid, [1] cycle_done
    output logic [ppps_pkg::OUT_USER_W-1:0] m_axis_tuser,

    input  logic                            cfg_we,
    input  logic [ppps_pkg::PCT_W-1:0]      cfg_wdata
);

    import ppps_pkg::*;

    localparam logic [DIV_DW-1:0] HALF_MAX = DIV_DW'(REV_STEPS / 2);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [PCT_W-1:0]    pct_reg;
    phase_t              phase_reg;
    logic                running_reg;
    logic                drive_on_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [STROKE_W-1:0] half_reg;
    logic [CNT_W-1:0]    phase_elapsed_reg;
    logic [CNT_W-1:0]    cycle_elapsed_reg;

    // working registers
    logic [CYC_W-1:0]    cyc_reg;
    logic [CYC_W-1:0]    sys_reg;
    logic [CYC_W-1:0]    dia_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   mcand_reg;
    logic [PCT_W-1:0]    mplier_reg;
    logic [MUL_CW-1:0]   mul_cnt_reg;
    logic [POS_W-1:0]    add_a_reg;     // position in, target out
    logic [POS_W-1:0]    add_b_reg;
    logic                carry_reg;
    logic [ADD_CW-1:0]   add_cnt_reg;

    // result flags gathered during the beat
    logic                res_move_reg;
    logic                res_prof_reg;
    logic                res_stop_reg;
    logic                res_zero_reg;
    logic                res_done_reg;
    logic [CNT_W-1:0]    res_clen_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_USER_W-1:0] m_user_reg;

    // ---------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------
    logic                s_acc;
    req_t                req_in;
    logic                out_free;

    logic                div_start;
    logic [DIV_DW-1:0]   div_dividend;
    logic [DIV_VW-1:0]   div_divisor;
    logic                div_done;
    logic [DIV_DW-1:0]   div_quo;

    logic [RATE_W:0]     rate_sum;
    logic [RATE_W-1:0]   rate_up;
    logic [RATE_W-1:0]   rate_dn;
    logic [DIV_DW-1:0]   half_ext;
    logic [DIV_DW-1:0]   stroke_up_num;
    logic [DIV_DW-1:0]   stroke_dn_num;
    logic [DIV_DW-1:0]   stroke_cl_hi;
    logic [DIV_DW-1:0]   stroke_cl;

    logic [CYC_W-1:0]    sys_clip;
    logic [CNT_W-1:0]    pe_inc;
    logic [CNT_W-1:0]    ce_inc;
    logic                sys_end;
    logic                dia_end;

    logic [DIG_W:0]      dig_sum;
    logic [POS_W-1:0]    target;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign req_in        = req_t'(s_axis_tuser);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // rate steps, clamped
    assign rate_sum = {1'b0, rate_reg} + (RATE_W + 1)'(RATE_STEP);
    assign rate_up  = (rate_sum > (RATE_W + 1)'(RATE_MAX)) ? RATE_W'(RATE_MAX)
                                                           : rate_sum[RATE_W-1:0];
    assign rate_dn  = (rate_reg < RATE_W'(RATE_MIN + RATE_STEP)) ? RATE_W'(RATE_MIN)
                                                                 : rate_reg - RATE_W'(RATE_STEP);

    // stroke * 11 or * 9, plus half the divisor for rounding
    assign half_ext      = DIV_DW'(half_reg);
    assign stroke_up_num = (half_ext << 3) + (half_ext << 1) + half_ext
                         + DIV_DW'(ROUND_HALF);
    assign stroke_dn_num = (half_ext << 3) + half_ext + DIV_DW'(ROUND_HALF);
    assign stroke_cl_hi  = (div_quo > HALF_MAX) ? HALF_MAX : div_quo;
    assign stroke_cl     = (stroke_cl_hi < DIV_DW'(STROKE_MIN)) ? DIV_DW'(STROKE_MIN)
                                                                : stroke_cl_hi;

    // systole share never beyond the full cycle
    assign sys_clip = (div_quo > DIV_DW'(cyc_reg)) ? cyc_reg : div_quo[CYC_W-1:0];

    // saturating counters and phase-end checks
    assign pe_inc  = (phase_elapsed_reg == '1) ? phase_elapsed_reg
                                               : phase_elapsed_reg + CNT_W'(1);
    assign ce_inc  = (cycle_elapsed_reg == '1) ? cycle_elapsed_reg
                                               : cycle_elapsed_reg + CNT_W'(1);
    assign sys_end = (phase_reg == PH_SYS) && (pe_inc >= CNT_W'(sys_reg));
    assign dia_end = (phase_reg == PH_DIA) && (pe_inc >= CNT_W'(dia_reg));

    // one 4-bit digit of the target per cycle
    assign dig_sum = {1'b0, add_a_reg[DIG_W-1:0]} + {1'b0, add_b_reg[DIG_W-1:0]}
                   + (DIG_W + 1)'(carry_reg);
    assign target  = res_move_reg ? add_a_reg : '0;

    // ---------------------------------------------------------------
    // shared serial divider
    // ---------------------------------------------------------------
    ppps_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (req_in)
                        REQ_TICK: begin
                            if (running_reg) begin
                                state_next   = ST_CYC;
                                div_start    = 1'b1;
                                div_dividend = DIV_DW'(MS_PER_MIN);
                                div_divisor  = DIV_VW'(rate_reg);
                            end else begin
                                state_next = ST_FIN;
                            end
                        end
                        REQ_START: begin
                            state_next = ST_ADD;
                        end
                        REQ_STROKE_UP: begin
                            state_next   = ST_STROKE;
                            div_start    = 1'b1;
                            div_dividend = stroke_up_num;
                            div_divisor  = DIV_VW'(STROKE_DIV);
                        end
                        REQ_STROKE_DN: begin
                            state_next   = ST_STROKE;
                            div_start    = 1'b1;
                            div_dividend = stroke_dn_num;
                            div_divisor  = DIV_VW'(STROKE_DIV);
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_CYC: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_cnt_reg == MUL_CW'(PCT_W - 1)) begin
                    state_next = ST_SYS_GO;
                end
            end
            ST_SYS_GO: begin
                state_next   = ST_SYS;
                div_start    = 1'b1;
                div_dividend = DIV_DW'(acc_reg);
                div_divisor  = DIV_VW'(PCT_SCALE);
            end
            ST_SYS: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = (sys_end || dia_end) ? ST_ADD : ST_FIN;
            end
            ST_STROKE: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_ADD: begin
                if (add_cnt_reg == ADD_CW'(ADD_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // pump state: phase, counters, rate, stroke, drive
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg           <= PCT_W'(PCT_RESET);
            phase_reg         <= PH_IDLE;
            running_reg       <= 1'b0;
            drive_on_reg      <= 1'b1;
            rate_reg          <= RATE_W'(START_RATE_BPM);
            half_reg          <= STROKE_W'(STROKE_STEPS / 2);
            phase_elapsed_reg <= '0;
            cycle_elapsed_reg <= '0;
        end else begin
            if (cfg_we) begin
                pct_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (req_in)
                            REQ_START: begin
                                running_reg       <= 1'b1;
                                phase_reg         <= PH_SYS;
                                phase_elapsed_reg <= '0;
                                cycle_elapsed_reg <= '0;
                            end
                            REQ_STOP: begin
                                running_reg <= 1'b0;
                                phase_reg   <= PH_IDLE;
                            end
                            REQ_ESTOP: begin
                                running_reg  <= 1'b0;
                                phase_reg    <= PH_IDLE;
                                drive_on_reg <= 1'b0;
                            end
                            REQ_RATE_UP: begin
                                rate_reg <= rate_up;
                            end
                            REQ_RATE_DN: begin
                                rate_reg <= rate_dn;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_EVAL: begin
                    if (sys_end) begin
                        phase_reg         <= PH_DIA;
                        phase_elapsed_reg <= '0;
                        cycle_elapsed_reg <= ce_inc;
                    end else if (dia_end) begin
                        phase_reg         <= PH_SYS;
                        phase_elapsed_reg <= '0;
                        cycle_elapsed_reg <= '0;
                    end else begin
                        phase_elapsed_reg <= pe_inc;
                        cycle_elapsed_reg <= ce_inc;
                    end
                end
                ST_STROKE: begin
                    if (div_done) begin
                        half_reg <= stroke_cl[STROKE_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath: multiplier, adder, result flags
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    add_a_reg    <= s_axis_tdata;
                    add_b_reg    <= POS_W'(half_reg);
                    carry_reg    <= 1'b0;
                    add_cnt_reg  <= '0;
                    res_move_reg <= (req_in == REQ_START);
                    res_prof_reg <= 1'b0;
                    res_stop_reg <= (req_in == REQ_STOP) || (req_in == REQ_ESTOP);
                    res_zero_reg <= (req_in == REQ_ESTOP);
                    res_done_reg <= 1'b0;
                    res_clen_reg <= '0;
                end
            end
            ST_CYC: begin
                if (div_done) begin
                    cyc_reg     <= div_quo[CYC_W-1:0];
                    mcand_reg   <= PROD_W'(div_quo[CYC_W-1:0]);
                    mplier_reg  <= pct_reg;
                    acc_reg     <= '0;
                    mul_cnt_reg <= '0;
                end
            end
            ST_MUL: begin
                // shift-add, one percent bit per cycle
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg   <= mcand_reg << 1;
                mplier_reg  <= mplier_reg >> 1;
                mul_cnt_reg <= mul_cnt_reg + MUL_CW'(1);
            end
            ST_SYS: begin
                if (div_done) begin
                    sys_reg <= sys_clip;
                    dia_reg <= cyc_reg - sys_clip;
                end
            end
            ST_EVAL: begin
                if (sys_end) begin
                    // diastole move: position minus stroke
                    res_move_reg <= 1'b1;
                    res_prof_reg <= 1'b1;
                    add_b_reg    <= ~POS_W'(half_reg);
                    carry_reg    <= 1'b1;
                end else if (dia_end) begin
                    res_move_reg <= 1'b1;
                    res_done_reg <= 1'b1;
                    res_clen_reg <= ce_inc;
                end
            end
            ST_ADD: begin
                add_a_reg   <= {dig_sum[DIG_W-1:0], add_a_reg[POS_W-1:DIG_W]};
                add_b_reg   <= add_b_reg >> DIG_W;
                carry_reg   <= dig_sum[DIG_W];
                add_cnt_reg <= add_cnt_reg + ADD_CW'(1);
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg <= {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                           half_reg,
                           rate_reg,
                           res_clen_reg,
                           drive_on_reg,
                           res_zero_reg,
                           res_stop_reg,
                           res_prof_reg,
                           target,
                           phase_reg};
            m_user_reg <= {res_done_reg, res_move_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `PPPS_ASSERT_IMP(a_run_phase, aclk, aresetn, running_reg, phase_reg != PH_IDLE, "running in idle phase")
    `PPPS_ASSERT_IMP(a_stop_phase, aclk, aresetn, !running_reg, phase_reg == PH_IDLE, "stopped but phase active")
    `PPPS_ASSERT_NXT(a_drive_latch, aclk, aresetn, !drive_on_reg, !drive_on_reg, "drive re-enabled without reset")
    `PPPS_ASSERT_IMP(a_rate_range, aclk, aresetn, 1'b1, rate_reg >= RATE_W'(RATE_MIN) && rate_reg <= RATE_W'(RATE_MAX), "rate out of range")
    `PPPS_ASSERT_NXT(a_fin_hold, aclk, aresetn, state_reg == ST_FIN && m_valid_reg && !m_axis_tready, state_reg == ST_FIN, "result lost while output stalled")

endmodule
